// ===== src/assert_macros.svh =====
// Assertion helpers shared by the FIFO and back-end modules.
// Both macros expect clk_i and rst_ni to be visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define STLT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("stlt: assertion failed");

// Condition that must never be seen at a clock edge outside reset.
`define STLT_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("stlt: forbidden condition seen");

`endif

// ===== src/stlt_pkg.sv =====
`default_nettype none

package stlt_pkg;

  // Default sizing of the block.
  localparam int MAX_SHORT_DEF   = 512;
  localparam int MAX_LONG_DEF    = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register widths and reset values.
  localparam int STA_W  = 10;
  localparam int LTA_W  = 13;
  localparam int TRIG_W = 16;

  localparam logic [STA_W-1:0]  STA_RESET  = 10'd50;
  localparam logic [LTA_W-1:0]  LTA_RESET  = 13'd500;
  localparam logic [TRIG_W-1:0] TRIG_RESET = 16'd1024;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STA_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LTA_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd2;

  // Output tdata is one byte; status sits in the low bits.
  localparam int OUT_TDATA_W = 8;
  localparam int STATUS_W    = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_WARM   = 2'd0,
    ST_GAP    = 2'd1,
    ST_NOPICK = 2'd2,
    ST_PICK   = 2'd3
  } status_e;

  typedef struct packed {
    logic [STA_W-1:0]  sta_len;
    logic [LTA_W-1:0]  lta_len;
    logic [TRIG_W-1:0] trigger_level;
  } cfg_t;

  // Back-end sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_CMP  = 5'b01000,
    S_OUT  = 5'b10000
  } back_state_e;

endpackage

`default_nettype wire

// ===== src/stlt_ram.sv =====
`default_nettype none

module stlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/stlt_fifo.sv =====
`default_nettype none

`include "assert_macros.svh"

module stlt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = stlt_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic      [WIDTH-1:0] pop_data_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_q;
  logic [PW-1:0]               wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]               rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]               count_q, count_d;
  logic                        push, pop;

  assign push_ready_o = (32'(count_q) < DEPTH);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `STLT_ASSERT_NEVER(a_fifo_overflow, 32'(count_q) > DEPTH)
  `STLT_ASSERT(a_fifo_ptr_gap, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))

endmodule

`default_nettype wire

// ===== src/stlt_front.sv =====
`default_nettype none

module stlt_front #(
  parameter int SAMPLE_BITS = stlt_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]   in_sample_i,
  input  wire logic                     in_present_i,
  output logic                          push_valid_o,
  input  wire logic                     push_ready_i,
  output logic      [2*SAMPLE_BITS-1:0] push_data_o
);

  localparam int SQ_W = 2 * SAMPLE_BITS - 1;

  logic                     valid_q, valid_d;
  logic [SAMPLE_BITS-1:0]   sample_q;
  logic                     present_q;
  logic                     accept;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] sq_full;

  assign in_ready_o = !valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Input holding stage.
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q  <= in_sample_i;
      present_q <= in_present_i;
    end
  end

  // Magnitude and square; the most negative code maps to its true magnitude.
  assign mag     = sample_q[SAMPLE_BITS-1] ? (~sample_q + SAMPLE_BITS'(1)) : sample_q;
  assign sq_full = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

  // Queue entry: gap flag on top, squared sample below.
  assign push_valid_o = valid_q;
  assign push_data_o  = {~present_q, sq_full[SQ_W-1:0]};

endmodule

`default_nettype wire

// ===== src/stlt_back.sv =====
`default_nettype none

`include "assert_macros.svh"

module stlt_back #(
  parameter int MAX_SHORT   = stlt_pkg::MAX_SHORT_DEF,
  parameter int MAX_LONG    = stlt_pkg::MAX_LONG_DEF,
  parameter int SAMPLE_BITS = stlt_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire stlt_pkg::cfg_t           cfg_i,
  input  wire logic                     restart_i,
  input  wire logic                     q_valid_i,
  output logic                          q_ready_o,
  input  wire logic [2*SAMPLE_BITS-1:0] q_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output stlt_pkg::status_e             out_status_o
);

  localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
  localparam int SPW     = $clog2(MAX_SHORT);
  localparam int LPW     = $clog2(MAX_LONG);
  localparam int LEN_SW  = $clog2(MAX_SHORT + 1);
  localparam int LEN_LW  = $clog2(MAX_LONG + 1);
  localparam int SSUM_W  = SQ_W + SPW;
  localparam int LSUM_W  = SQ_W + LPW;
  localparam int MAXS_W  = (SSUM_W > LSUM_W) ? SSUM_W : LSUM_W;
  localparam int NCH_RAW = (MAXS_W + 31) / 32;
  localparam int NCH     = (NCH_RAW < 2) ? 2 : NCH_RAW;
  localparam int CHW     = $clog2(NCH);
  localparam int SUMX_W  = NCH * 32;
  localparam int TS_W    = stlt_pkg::TRIG_W + LEN_SW;
  localparam int LACC_W  = SUMX_W + LEN_LW;
  localparam int RACC_W  = SUMX_W + TS_W;
  localparam int CMP_W   = (LACC_W + 8 > RACC_W) ? LACC_W + 8 : RACC_W;

  stlt_pkg::back_state_e state_q, state_d;
  stlt_pkg::status_e     res_q, res_d;
  stlt_pkg::status_e     out_status_q;
  logic                  out_valid_q, out_valid_d;
  logic                  out_load;

  logic [SSUM_W-1:0] ssum_q, ssum_d;
  logic [LSUM_W-1:0] lsum_q, lsum_d;
  logic [SPW-1:0]    sptr_q, sptr_d, sidx_q, sidx_d, sidx_c;
  logic [LPW-1:0]    lptr_q, lptr_d, lidx_q, lidx_d, lidx_c;
  logic [LEN_LW-1:0] fill_q, fill_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [TS_W-1:0]   ts_q, ts_d;
  logic [LACC_W-1:0] lacc_q, lacc_d;
  logic [RACC_W-1:0] racc_q, racc_d;
  logic [CHW-1:0]    chunk_q, chunk_d;

  logic [31:0]       l32, s32, snext32, lnext32;
  logic [LEN_LW-1:0] l_eff;
  logic [LEN_SW-1:0] s_eff;
  logic              ring_re, ring_we;
  logic [SQ_W-1:0]   srd, lrd, ssub, lsub;
  logic [LSUM_W-1:0] den;
  logic [NCH-1:0][31:0] sx, dx;
  logic [32+LEN_LW-1:0] prod_l;
  logic [32+TS_W-1:0]   prod_r;
  logic [CMP_W-1:0]     cmp_lhs, cmp_rhs;
  logic                 q_gap;
  logic [SQ_W-1:0]      q_sq;

  assign q_gap = q_data_i[SQ_W];
  assign q_sq  = q_data_i[SQ_W-1:0];

  // Effective window lengths: long clamped to its store, short also to the long one.
  always_comb begin
    l32 = 32'(cfg_i.lta_len);
    if (l32 == 32'd0) begin
      l32 = 32'd1;
    end else if (l32 > 32'(MAX_LONG)) begin
      l32 = 32'(MAX_LONG);
    end
    s32 = 32'(cfg_i.sta_len);
    if (s32 == 32'd0) begin
      s32 = 32'd1;
    end else if (s32 > 32'(MAX_SHORT)) begin
      s32 = 32'(MAX_SHORT);
    end
    if (s32 > l32) begin
      s32 = l32;
    end
  end

  assign l_eff = LEN_LW'(l32);
  assign s_eff = LEN_SW'(s32);

  // Ring positions for this sample, wrapped if they lie outside the window.
  assign sidx_c  = (32'(sptr_q) >= s32) ? '0 : sptr_q;
  assign lidx_c  = (32'(lptr_q) >= l32) ? '0 : lptr_q;
  assign snext32 = 32'(sidx_q) + 32'd1;
  assign lnext32 = 32'(lidx_q) + 32'd1;

  // Oldest entry leaves a window only once that window has filled.
  assign ssub = (32'(fill_q) >= s32) ? srd : '0;
  assign lsub = (32'(fill_q) >= l32) ? lrd : '0;

  // Operands of the chunked cross multiplication; a zero long sum counts as one.
  assign den = (lsum_q == '0) ? LSUM_W'(1) : lsum_q;
  assign sx  = SUMX_W'(ssum_q);
  assign dx  = SUMX_W'(den);

  assign prod_l = {{LEN_LW{1'b0}}, sx[chunk_q]} * {32'd0, l_eff};
  assign prod_r = {{TS_W{1'b0}}, dx[chunk_q]} * {32'd0, ts_q};

  assign cmp_lhs = CMP_W'({lacc_q, 8'h00});
  assign cmp_rhs = CMP_W'(racc_q);

  assign q_ready_o = (state_q == stlt_pkg::S_IDLE);
  assign out_load  = (state_q == stlt_pkg::S_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer: read rings, update sums, multiply chunk by chunk, compare.
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    ssum_d  = ssum_q;
    lsum_d  = lsum_q;
    sptr_d  = sptr_q;
    lptr_d  = lptr_q;
    sidx_d  = sidx_q;
    lidx_d  = lidx_q;
    fill_d  = fill_q;
    sq_d    = sq_q;
    ts_d    = ts_q;
    lacc_d  = lacc_q;
    racc_d  = racc_q;
    chunk_d = chunk_q;
    ring_re = 1'b0;
    ring_we = 1'b0;
    case (state_q)
      stlt_pkg::S_IDLE: begin
        if (q_valid_i) begin
          if (q_gap) begin
            ssum_d  = '0;
            lsum_d  = '0;
            sptr_d  = '0;
            lptr_d  = '0;
            fill_d  = '0;
            res_d   = stlt_pkg::ST_GAP;
            state_d = stlt_pkg::S_OUT;
          end else begin
            sq_d    = q_sq;
            sidx_d  = sidx_c;
            lidx_d  = lidx_c;
            ts_d    = {{LEN_SW{1'b0}}, cfg_i.trigger_level} *
                      {{stlt_pkg::TRIG_W{1'b0}}, s_eff};
            ring_re = 1'b1;
            state_d = stlt_pkg::S_READ;
          end
        end
      end
      stlt_pkg::S_READ: begin
        ssum_d  = ssum_q - SSUM_W'(ssub) + SSUM_W'(sq_q);
        lsum_d  = lsum_q - LSUM_W'(lsub) + LSUM_W'(sq_q);
        ring_we = 1'b1;
        sptr_d  = (snext32 >= s32) ? '0 : SPW'(snext32);
        lptr_d  = (lnext32 >= l32) ? '0 : LPW'(lnext32);
        if (32'(fill_q) >= l32) begin
          lacc_d  = '0;
          racc_d  = '0;
          chunk_d = CHW'(NCH - 1);
          state_d = stlt_pkg::S_MUL;
        end else begin
          fill_d  = fill_q + LEN_LW'(1);
          res_d   = stlt_pkg::ST_WARM;
          state_d = stlt_pkg::S_OUT;
        end
      end
      stlt_pkg::S_MUL: begin
        // Most significant chunk first, so the running product shifts by a constant.
        lacc_d = {lacc_q[LACC_W-33:0], 32'h0} + LACC_W'(prod_l);
        racc_d = {racc_q[RACC_W-33:0], 32'h0} + RACC_W'(prod_r);
        if (chunk_q == '0) begin
          state_d = stlt_pkg::S_CMP;
        end else begin
          chunk_d = chunk_q - CHW'(1);
        end
      end
      stlt_pkg::S_CMP: begin
        res_d   = (cmp_lhs >= cmp_rhs) ? stlt_pkg::ST_PICK : stlt_pkg::ST_NOPICK;
        state_d = stlt_pkg::S_OUT;
      end
      stlt_pkg::S_OUT: begin
        if (out_load) begin
          state_d = stlt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = stlt_pkg::S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stlt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      ssum_q      <= '0;
      lsum_q      <= '0;
      sptr_q      <= '0;
      lptr_q      <= '0;
      fill_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (restart_i) begin
        ssum_q <= '0;
        lsum_q <= '0;
        sptr_q <= '0;
        lptr_q <= '0;
        fill_q <= '0;
      end else begin
        ssum_q <= ssum_d;
        lsum_q <= lsum_d;
        sptr_q <= sptr_d;
        lptr_q <= lptr_d;
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    sidx_q  <= sidx_d;
    lidx_q  <= lidx_d;
    sq_q    <= sq_d;
    ts_q    <= ts_d;
    lacc_q  <= lacc_d;
    racc_q  <= racc_d;
    chunk_q <= chunk_d;
    if (out_load) begin
      out_status_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;

  // Ring stores of squared samples.
  stlt_ram #(
    .WIDTH(SQ_W),
    .DEPTH(MAX_SHORT)
  ) u_short_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(sidx_q),
    .wdata_i(sq_q),
    .re_i   (ring_re),
    .raddr_i(sidx_c),
    .rdata_o(srd)
  );

  stlt_ram #(
    .WIDTH(SQ_W),
    .DEPTH(MAX_LONG)
  ) u_long_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(lidx_q),
    .wdata_i(sq_q),
    .re_i   (ring_re),
    .raddr_i(lidx_c),
    .rdata_o(lrd)
  );

  `STLT_ASSERT(a_cmp_after_mul, (state_q == stlt_pkg::S_CMP) |-> ($past(state_q) == stlt_pkg::S_MUL))
  `STLT_ASSERT(a_sidx_in_window, (state_q == stlt_pkg::S_READ) |-> (32'(sidx_q) < s32))
  `STLT_ASSERT(a_lidx_in_window, (state_q == stlt_pkg::S_READ) |-> (32'(lidx_q) < l32))
  `STLT_ASSERT_NEVER(a_fill_overrun, 32'(fill_q) > l32)

endmodule

`default_nettype wire

// ===== src/sta_lta_trigger_unit.sv =====
// STA/LTA energy trigger. Each beat on the input stream carries one signed sample in tdata
// and a present flag in tuser; each input beat yields exactly one status beat (0 warming up,
// 1 gap, 2 no pick, 3 pick). A front stage squares the sample and places it in a two-entry
// queue, so input keeps flowing while the back end works; the back end reads both ring
// memories, updates the short and long sums and, once the long window has filled, compares
// short_sum * L * 256 against trigger_level * max(long_sum, 1) * S with two 32-bit chunked
// multipliers, one per side, over the NCH 32-bit chunks of the wider sum (two at the default
// sizes). Warm-up samples and gaps skip the multiply, and the back end takes a new sample
// only when idle, so the chunked multiply sets the tested rate. The ring memories are not
// cleared after reset; entries are only used after being written since the last restart.
// Any configuration write to a known index restarts the warm-up, as a gap does.
`default_nettype none

module sta_lta_trigger_unit #(
  parameter int MAX_SHORT   = stlt_pkg::MAX_SHORT_DEF,
  parameter int MAX_LONG    = stlt_pkg::MAX_LONG_DEF,
  parameter int SAMPLE_BITS = stlt_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration write port.
  input  wire logic                                  cfg_we_i,
  input  wire logic [stlt_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [stlt_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // Sample stream in.
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample
  input  wire logic                                  s_axis_tuser,  // present
  // Status stream out.
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic      [stlt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // status, zeros
);

  stlt_pkg::cfg_t            cfg_q;
  logic                      restart;
  logic                      push_valid, push_ready;
  logic [2*SAMPLE_BITS-1:0]  push_data;
  logic                      pop_valid, pop_ready;
  logic [2*SAMPLE_BITS-1:0]  pop_data;
  stlt_pkg::status_e         status;

  // Configuration registers; a write to a known index restarts the warm-up.
  always_comb begin
    case (cfg_idx_i)
      stlt_pkg::CFG_STA_LEN,
      stlt_pkg::CFG_LTA_LEN,
      stlt_pkg::CFG_TRIGGER: restart = cfg_we_i;
      default:               restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sta_len       <= stlt_pkg::STA_RESET;
      cfg_q.lta_len       <= stlt_pkg::LTA_RESET;
      cfg_q.trigger_level <= stlt_pkg::TRIG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stlt_pkg::CFG_STA_LEN: cfg_q.sta_len       <= cfg_data_i[stlt_pkg::STA_W-1:0];
        stlt_pkg::CFG_LTA_LEN: cfg_q.lta_len       <= cfg_data_i[stlt_pkg::LTA_W-1:0];
        stlt_pkg::CFG_TRIGGER: cfg_q.trigger_level <= cfg_data_i[stlt_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and square.
  stlt_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_present_i(s_axis_tuser),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  // Queue between front and back end.
  stlt_fifo #(
    .WIDTH(2 * SAMPLE_BITS),
    .DEPTH(stlt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // Back end: windows, sums and the pick decision.
  stlt_back #(
    .MAX_SHORT  (MAX_SHORT),
    .MAX_LONG   (MAX_LONG),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .restart_i   (restart),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_data_i    (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(status)
  );

  assign m_axis_tdata = {{(stlt_pkg::OUT_TDATA_W - stlt_pkg::STATUS_W){1'b0}}, status};

endmodule

`default_nettype wire

// ===== tb/sv/tb_sta_lta_trigger_unit.sv =====
`timescale 1ns / 100ps

module tb_sta_lta_trigger_unit;
  import stlt_pkg::*;

  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  // Index past the register list; a write there must leave the block alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Energy-trigger predictor plus the queue of status values still owed by the block.
  class status_scoreboard;
    logic [STA_W-1:0]  sta_len;
    logic [LTA_W-1:0]  lta_len;
    logic [TRIG_W-1:0] trig_level;
    logic [63:0]       short_energy [MAX_SHORT_DEF];
    logic [63:0]       long_energy [MAX_LONG_DEF];
    logic [63:0]       short_sum;
    logic [63:0]       long_sum;
    int unsigned       short_ptr;
    int unsigned       long_ptr;
    int unsigned       fill_count;
    status_e           expected_status[$];
    int unsigned       errors;
    int unsigned       samples_seen;
    int unsigned       checked;
    int unsigned       picks;
    int unsigned       gaps;

    function new();
      sta_len = STA_RESET;
      lta_len = LTA_RESET;
      trig_level = TRIG_RESET;
      errors = 0;
      samples_seen = 0;
      checked = 0;
      picks = 0;
      gaps = 0;
      restart_window();
    endfunction

    function void restart_window();
      short_sum = '0;
      long_sum = '0;
      short_ptr = 0;
      long_ptr = 0;
      fill_count = 0;
    endfunction

    // Any valid register write restarts the warm-up, as a gap does.
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_STA_LEN: sta_len = data[STA_W-1:0];
        CFG_LTA_LEN: lta_len = data[LTA_W-1:0];
        CFG_TRIGGER: trig_level = data[TRIG_W-1:0];
        default: return;
      endcase
      restart_window();
    endfunction

    // Work out the status for one accepted input beat.
    function void note_sample(logic [SAMPLE_W-1:0] smp, logic present);
      int unsigned win_l;
      int unsigned win_s;
      longint      amp;
      logic [63:0] sq;
      logic [63:0] den;
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic        tested;
      samples_seen++;
      win_l = lta_len;
      if (win_l < 1) win_l = 1;
      if (win_l > MAX_LONG_DEF) win_l = MAX_LONG_DEF;
      win_s = sta_len;
      if (win_s < 1) win_s = 1;
      if (win_s > MAX_SHORT_DEF) win_s = MAX_SHORT_DEF;
      if (win_s > win_l) win_s = win_l;

      if (!present) begin
        restart_window();
        expected_status.push_back(ST_GAP);
        return;
      end

      amp = longint'($signed(smp));
      if (amp < 0) amp = -amp;
      sq = 64'(amp * amp);

      if (short_ptr >= win_s) short_ptr = 0;
      if (long_ptr >= win_l) long_ptr = 0;
      tested = (fill_count >= win_l);

      // Slide the short window; old entries leave only once the ring has filled.
      if (fill_count >= win_s) short_sum -= short_energy[short_ptr];
      short_energy[short_ptr] = sq;
      short_sum += sq;
      short_ptr = (short_ptr + 1 >= win_s) ? 0 : short_ptr + 1;

      // Same for the long window.
      if (tested) long_sum -= long_energy[long_ptr];
      long_energy[long_ptr] = sq;
      long_sum += sq;
      long_ptr = (long_ptr + 1 >= win_l) ? 0 : long_ptr + 1;

      if (tested) begin
        // Cross-multiplied ratio test; an empty long window counts as one.
        den = (long_sum == 0) ? 64'd1 : long_sum;
        lhs = 128'(short_sum) * 128'(64'(win_l) * 64'd256);
        rhs = 128'(den) * 128'(64'(trig_level) * 64'(win_s));
        expected_status.push_back((lhs >= rhs) ? ST_PICK : ST_NOPICK);
      end else begin
        fill_count++;
        expected_status.push_back(ST_WARM);
      end
    endfunction

    // Compare one output beat with the oldest expected status.
    function void check_status(logic [OUT_TDATA_W-1:0] beat);
      status_e want;
      if (expected_status.size() == 0) begin
        $error("status: no beat expected, got 0x%0h", beat);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      checked++;
      if (want == ST_PICK) picks++;
      if (want == ST_GAP) gaps++;
      if (beat[STATUS_W-1:0] !== want) begin
        $error("status: expected %0d, got %0d", want, beat[STATUS_W-1:0]);
        errors++;
      end
      if (beat[OUT_TDATA_W-1:STATUS_W] !== '0) begin
        $error("tdata pad: expected 0, got 0x%0h", beat[OUT_TDATA_W-1:STATUS_W]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [SAMPLE_W-1:0]    s_axis_tdata;   // sample
  logic                   s_axis_tuser;   // present
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // status, zeros

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  status_scoreboard board;

  sta_lta_trigger_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Status sink: check each accepted beat, then pick the next ready level.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      board.check_status(m_axis_tdata);
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("sta_lta_trigger_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one input beat, with random idle cycles ahead of it.
  task automatic send_beat(logic [SAMPLE_W-1:0] smp, logic present);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= present;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_sample(smp, present);
  endtask

  // Register write, only once every owed status has come back.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_register(idx, data);
  endtask

  task automatic set_windows(int unsigned sta, int unsigned lta, int unsigned trig);
    write_cfg(CFG_STA_LEN, CFG_DATA_W'(sta));
    write_cfg(CFG_LTA_LEN, CFG_DATA_W'(lta));
    write_cfg(CFG_TRIGGER, CFG_DATA_W'(trig));
  endtask

  // Signed noise limited to the given number of bits; zero bits gives silence.
  function automatic logic [SAMPLE_W-1:0] noise_sample(int unsigned bits);
    logic [SAMPLE_W-1:0] raw;
    raw = SAMPLE_W'($urandom);
    if (bits == 0) return '0;
    return SAMPLE_W'($signed(raw) >>> (SAMPLE_W - bits));
  endfunction

  // Sample stream whose energy level jumps now and then, so the ratio crosses the
  // threshold both ways; gaps are thrown in at the given rate per thousand.
  task automatic run_stream(int unsigned count, int unsigned gap_per_mille);
    int unsigned bits;
    int unsigned n;
    bits = $urandom_range(24, 1);
    for (n = 0; n < count; n++) begin
      if ($urandom_range(15) == 0) bits = $urandom_range(24, 0);
      if ($urandom_range(999) < gap_per_mille) begin
        send_beat(SAMPLE_W'($urandom), 1'b0);
      end else begin
        send_beat(noise_sample(bits), 1'b1);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    board = new();
    quiet_cycles = 0;
    send_idle_pct = 31;
    recv_idle_pct = 66;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_STA_LEN;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tiny windows, sample extremes, silence and gaps in each stage.
    set_windows(2, 3, 256);
    send_beat(24'hFFFFFF, 1'b0);
    send_beat(24'h7FFFFF, 1'b1);
    send_beat(24'h800000, 1'b1);
    send_beat(24'hFFFFFF, 1'b0);
    send_beat(24'hFFFFFF, 1'b1);
    send_beat(24'h000001, 1'b1);
    send_beat(24'h800000, 1'b1);
    send_beat(24'h000000, 1'b1);
    send_beat(24'h000000, 1'b1);
    send_beat(24'h000000, 1'b1);
    send_beat(24'h000000, 1'b1);
    send_beat(24'h7FFFFF, 1'b1);
    send_beat(24'h555555, 1'b1);
    send_beat(24'hAAAAAA, 1'b1);
    send_beat(24'h000001, 1'b1);
    send_beat(24'h000000, 1'b0);
    send_beat(24'h123456, 1'b1);
    send_beat(24'hFEDCBA, 1'b1);
    send_beat(24'h000010, 1'b1);
    send_beat(24'h7FFFFF, 1'b1);
    s_axis_tvalid <= 1'b0;

    // Zero trigger picks on every tested sample; then zero lengths clamp to one.
    set_windows(1, 1, 0);
    run_stream(40, 30);
    set_windows(0, 0, 65535);
    run_stream(40, 30);
    set_windows(8, 32, 512);
    run_stream(150, 10);

    send_idle_pct = 66;
    recv_idle_pct = 31;
    // Short length above the long one is cut down to it.
    set_windows(20, 10, 300);
    run_stream(100, 20);
    set_windows($urandom_range(64, 1), $urandom_range(128, 1), $urandom_range(1024, 64));
    run_stream(150, 10);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Unused register index: the windows keep running without a restart.
    write_cfg(CFG_UNUSED_IDX, 16'hFFFF);
    run_stream(60, 0);
    // Largest field values, clamped to the ring depths; the warm-up runs on them.
    set_windows(1023, 8191, 256);
    run_stream(40, 0);
    send_beat(SAMPLE_W'($urandom), 1'b0);
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d sample beats and checked %0d status beats (%0d picks, %0d gaps).",
             board.samples_seen, board.checked, board.picks, board.gaps);
    $display("Windows ran from one sample up to the clamped maximum lengths, triggers 0 to 65535.");
    if (board.errors == 0) begin
      $display("sta_lta_trigger_unit: match");
    end else begin
      $display("sta_lta_trigger_unit: mismatch");
    end
    $finish;
  end

endmodule
